/* hdl/trsa_pkg.sv */
package trsa_pkg;

    localparam int TOTAL_SLOTS_DEF = 1024;
    localparam int HIGH_START_DEF  = 512;

    localparam int OP_W       = 2;
    localparam int HANDLE_W   = 16;
    localparam int SLOT_ID_W  = 16;
    localparam int SLOT_OUT_W = 10;
    localparam int COUNT_W    = 10;

    // valid map is kept as words of this many bits
    localparam int WORD_BITS = 32;
    localparam int WORD_SH   = 5;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN1,
        ST_SCAN2,
        ST_EVAL,
        ST_PUSH
    } t_state;

endpackage

/* hdl/trsa_if.sv */
interface trsa_req_if import trsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic                 kind;
    logic [HANDLE_W-1:0]  handle;
    logic [SLOT_ID_W-1:0] slot_id;

    modport source (output valid, op, kind, handle, slot_id, input ready);
    modport sink   (input valid, op, kind, handle, slot_id, output ready);
endinterface

interface trsa_rsp_if import trsa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [HANDLE_W-1:0]   handle_out;
    logic [COUNT_W-1:0]    low_count;
    logic [COUNT_W-1:0]    high_count;

    modport source (output valid, ok, slot_out, handle_out, low_count, high_count,
                    input ready);
    modport sink   (input valid, ok, slot_out, handle_out, low_count, high_count,
                    output ready);
endinterface

/* hdl/trsa_ram.sv */
module trsa_ram import trsa_pkg::*; #(
    parameter int DATA_W = HANDLE_W,
    parameter int DEPTH  = TOTAL_SLOTS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read: data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/two_region_slot_id_allocator.sv */
// Channel   Dir  Modport         Beat contents
// i_req     in   trsa_req_if     op, kind, handle, slot_id
// o_rsp     out  trsa_rsp_if     ok, slot_out, handle_out, low_count, high_count
//
// One request at a time. An unused op goes straight to the push. Remove/get:
// one valid map read, one evaluate, one push. Add: up to two free-slot scans over
// the region's valid-map words, one 32-bit word per cycle on the valid map read
// port. After reset the valid map is zeroed one word a cycle with ready low. A
// result waiting in the output register does not block the next request; only a
// new result waits for it to drain.
module two_region_slot_id_allocator import trsa_pkg::*; #(
    parameter int TOTAL_SLOTS = TOTAL_SLOTS_DEF,
    parameter int HIGH_START  = HIGH_START_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    trsa_req_if.sink   i_req,
    trsa_rsp_if.source o_rsp
);

    // ---- sizes ---------------------------------------------------------
    localparam int SIW   = $clog2(TOTAL_SLOTS);           // slot index
    localparam int SW1   = $clog2(TOTAL_SLOTS + 1);       // slot bound
    localparam int PW    = (SW1 > WORD_SH + 1) ? SW1 : WORD_SH + 1;
    localparam int XW    = PW - WORD_SH;                  // word number of a bound
    localparam int WORDS = (TOTAL_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int LOW_END    = (HIGH_START < TOTAL_SLOTS) ? HIGH_START : TOTAL_SLOTS;
    localparam bit HIGH_EMPTY = (LOW_END >= TOTAL_SLOTS);

    localparam logic [PW-1:0] LOW_END_P = PW'(LOW_END);
    localparam logic [PW-1:0] TOTAL_P   = PW'(TOTAL_SLOTS);
    localparam logic [WA-1:0] LOW_LAST_W  = WA'((LOW_END - 1) / WORD_BITS);
    localparam logic [WA-1:0] HIGH_BASE_W = WA'(LOW_END / WORD_BITS);
    localparam logic [WA-1:0] HIGH_LAST_W = WA'((TOTAL_SLOTS - 1) / WORD_BITS);
    localparam logic [WA-1:0] CLR_LAST    = WA'(WORDS - 1);
    localparam logic [SLOT_ID_W-1:0] SID_TOTAL = SLOT_ID_W'(TOTAL_SLOTS);
    localparam logic [SLOT_ID_W-1:0] SID_LOW_END = SLOT_ID_W'(LOW_END);

    // ---- state ---------------------------------------------------------
    t_state r_state, n_state;

    logic [WA-1:0]         r_clr;
    logic [PW-1:0]         r_lo_cur, r_hi_cur;
    logic [COUNT_W-1:0]    r_low_cnt, r_high_cnt;

    // request capture
    logic                  r_kind;
    logic [HANDLE_W-1:0]   r_handle;
    logic [SLOT_ID_W-1:0]  r_sid;
    logic                  r_inr;
    logic                  r_is_get;

    // add bookkeeping
    logic [PW-1:0]         r_slot;      // slot taken by first scan
    t_word                 r_hit_word;  // its valid word with the new bit set
    logic [WA-1:0]         r_hit_w;

    // scan engine: issue side
    logic [PW-1:0]         r_st;        // scan start slot
    logic                  r_ex_en;     // treat r_slot as taken
    logic [WA-1:0]         r_aw;
    logic                  r_ap;        // 0 start..region end, 1 wrapped pass
    logic                  r_iss;
    // scan engine: data side, aligned with valid map read data
    logic                  r_dv;
    logic [WA-1:0]         r_dw;
    logic                  r_dp;

    // result and output registers
    logic                  r_res_ok;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic [HANDLE_W-1:0]   r_res_handle;
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [COUNT_W-1:0]    r_out_low, r_out_high;

    // ---- memories ------------------------------------------------------
    logic            vm_we;
    logic [WA-1:0]   vm_waddr, vm_raddr;
    t_word           vm_wdata, vm_rdata;
    logic            hs_we;
    logic [SIW-1:0]  hs_waddr;
    logic [HANDLE_W-1:0] hs_rdata;

    trsa_ram #(.DATA_W(WORD_BITS), .DEPTH(WORDS)) u_valid_map (
        .i_clk   (i_clk),
        .i_we    (vm_we),
        .i_waddr (vm_waddr),
        .i_wdata (vm_wdata),
        .i_raddr (vm_raddr),
        .o_rdata (vm_rdata)
    );

    trsa_ram #(.DATA_W(HANDLE_W), .DEPTH(TOTAL_SLOTS)) u_handle_store (
        .i_clk   (i_clk),
        .i_we    (hs_we),
        .i_waddr (hs_waddr),
        .i_wdata (r_handle),
        .i_raddr (i_req.slot_id[SIW-1:0]),
        .o_rdata (hs_rdata)
    );

    // ---- request decode --------------------------------------------------
    logic req_acc;
    t_op  req_op;
    assign req_acc = (r_state == ST_IDLE) && i_req.valid;
    assign req_op  = t_op'(i_req.op);

    logic add_trivial_fail;
    assign add_trivial_fail = (i_req.handle == '0) || (i_req.kind && HIGH_EMPTY);

    logic out_free;
    assign out_free = !r_out_valid || o_rsp.ready;

    // ---- scan evaluation -------------------------------------------------
    logic [PW-1:0] base_p, end_p;
    logic [WA-1:0] base_w, last_w, st_w;
    assign base_p = r_kind ? LOW_END_P : '0;
    assign end_p  = r_kind ? TOTAL_P : LOW_END_P;
    assign base_w = r_kind ? HIGH_BASE_W : '0;
    assign last_w = r_kind ? HIGH_LAST_W : LOW_LAST_W;
    assign st_w   = r_st[WORD_SH +: WA];

    // first pass covers [start, end), wrapped pass [base, start)
    logic [PW-1:0]      lo_p, hi_p;
    logic [XW-1:0]      dw_x;
    t_word              m_lo, m_hi, m_ex, cand, lsb;
    logic [WORD_SH-1:0] enc;
    logic               s_hit, s_last, s_done;
    logic [PW-1:0]      found_p;

    assign lo_p = r_dp ? base_p : r_st;
    assign hi_p = r_dp ? r_st : end_p;
    assign dw_x = XW'(r_dw);

    always_comb begin
        if (lo_p[PW-1:WORD_SH] < dw_x) begin
            m_lo = '1;
        end else if (lo_p[PW-1:WORD_SH] == dw_x) begin
            m_lo = '1 << lo_p[WORD_SH-1:0];
        end else begin
            m_lo = '0;
        end
        if (hi_p[PW-1:WORD_SH] > dw_x) begin
            m_hi = '1;
        end else if (hi_p[PW-1:WORD_SH] == dw_x) begin
            m_hi = ~('1 << hi_p[WORD_SH-1:0]);
        end else begin
            m_hi = '0;
        end
        if (r_ex_en && (r_slot[PW-1:WORD_SH] == dw_x)) begin
            m_ex = ~(t_word'(1) << r_slot[WORD_SH-1:0]);
        end else begin
            m_ex = '1;
        end
    end

    assign cand = ~vm_rdata & m_lo & m_hi & m_ex;
    assign lsb  = cand & (~cand + t_word'(1));   // lowest free bit only

    always_comb begin
        enc = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lsb[j]) begin
                enc = enc | WORD_SH'(j);
            end
        end
    end

    assign found_p = {dw_x, enc};
    assign s_hit   = r_dv && (cand != '0);
    assign s_last  = r_dv && r_dp && (r_dw == st_w);
    assign s_done  = s_hit || s_last;

    // slot after the one just taken, wrapping inside the region
    logic [PW-1:0] after_p;
    always_comb begin
        after_p = found_p + PW'(1);
        if (after_p == end_p) begin
            after_p = base_p;
        end
    end

    // ---- remove / get evaluation -----------------------------------------
    logic  rg_hit;
    t_word rg_clear_word;
    assign rg_hit        = r_inr && vm_rdata[r_sid[WORD_SH-1:0]];
    assign rg_clear_word = vm_rdata & ~(t_word'(1) << r_sid[WORD_SH-1:0]);

    // ---- next state ------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    unique case (req_op)
                        OP_ADD:    n_state = add_trivial_fail ? ST_PUSH : ST_SCAN1;
                        OP_REMOVE: n_state = ST_EVAL;
                        OP_GET:    n_state = ST_EVAL;
                        default:   n_state = ST_PUSH;
                    endcase
                end
            end
            ST_SCAN1: begin
                if (s_done) n_state = s_hit ? ST_SCAN2 : ST_PUSH;
            end
            ST_SCAN2: begin
                if (s_done) n_state = ST_PUSH;
            end
            ST_EVAL: n_state = ST_PUSH;
            ST_PUSH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- control outputs -------------------------------------------------
    logic          s_start;
    logic [PW-1:0] s_start_slot;

    always_comb begin
        vm_we        = 1'b0;
        vm_waddr     = r_clr;
        vm_wdata     = '0;
        vm_raddr     = r_aw;
        hs_we        = 1'b0;
        hs_waddr     = found_p[SIW-1:0];
        s_start      = 1'b0;
        s_start_slot = after_p;
        unique case (r_state)
            ST_CLEAR: begin
                vm_we = 1'b1;
            end
            ST_IDLE: begin
                vm_raddr = i_req.slot_id[WORD_SH +: WA];
                if (i_req.valid && (req_op == OP_ADD) && !add_trivial_fail) begin
                    s_start      = 1'b1;
                    s_start_slot = i_req.kind ? r_hi_cur : r_lo_cur;
                end
            end
            ST_SCAN1: begin
                if (s_hit) begin
                    hs_we   = 1'b1;
                    s_start = 1'b1;
                end
            end
            ST_SCAN2: begin
                if (s_done) begin
                    vm_we    = 1'b1;
                    vm_waddr = r_hit_w;
                    vm_wdata = r_hit_word;
                end
            end
            ST_EVAL: begin
                if (!r_is_get && rg_hit) begin
                    vm_we    = 1'b1;
                    vm_waddr = r_sid[WORD_SH +: WA];
                    vm_wdata = rg_clear_word;
                end
            end
            ST_PUSH: ;
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);

    // ---- registers -------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr <= r_clr + WA'(1);
        end
    end

    // scan engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= 1'b0;
            r_dv  <= 1'b0;
        end else if (s_start) begin
            r_st    <= s_start_slot;
            r_ex_en <= (r_state == ST_SCAN1);
            r_aw    <= s_start_slot[WORD_SH +: WA];
            r_ap    <= 1'b0;
            r_iss   <= 1'b1;
            r_dv    <= 1'b0;
        end else if (s_done) begin
            r_iss <= 1'b0;
            r_dv  <= 1'b0;
        end else begin
            r_dv <= r_iss;
            r_dw <= r_aw;
            r_dp <= r_ap;
            if (r_iss) begin
                if (!r_ap && (r_aw == last_w)) begin
                    r_aw <= base_w;
                    r_ap <= 1'b1;
                end else if (r_ap && (r_aw == st_w)) begin
                    r_iss <= 1'b0;
                end else begin
                    r_aw <= r_aw + WA'(1);
                end
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_kind   <= i_req.kind;
            r_handle <= i_req.handle;
            r_sid    <= i_req.slot_id;
            r_inr    <= (i_req.slot_id < SID_TOTAL);
            r_is_get <= (req_op == OP_GET);
        end
        if ((r_state == ST_SCAN1) && s_hit) begin
            r_slot     <= found_p;
            r_hit_word <= vm_rdata | lsb;
            r_hit_w    <= r_dw;
        end
    end

    // cursors and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_cur   <= '0;
            r_hi_cur   <= LOW_END_P;
            r_low_cnt  <= '0;
            r_high_cnt <= '0;
        end else if ((r_state == ST_SCAN2) && s_done) begin
            // next free slot becomes the cursor; if none, the slot just taken
            if (r_kind) begin
                r_hi_cur   <= s_hit ? found_p : r_slot;
                r_high_cnt <= r_high_cnt + COUNT_W'(1);
            end else begin
                r_lo_cur  <= s_hit ? found_p : r_slot;
                r_low_cnt <= r_low_cnt + COUNT_W'(1);
            end
        end else if ((r_state == ST_EVAL) && !r_is_get && rg_hit) begin
            if (r_sid >= SID_LOW_END) begin
                r_high_cnt <= r_high_cnt - COUNT_W'(1);
            end else begin
                r_low_cnt <= r_low_cnt - COUNT_W'(1);
            end
        end
    end

    // result
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_res_ok     <= 1'b0;
            r_res_slot   <= '0;
            r_res_handle <= '0;
        end else if ((r_state == ST_SCAN2) && s_done) begin
            r_res_ok   <= 1'b1;
            r_res_slot <= SLOT_OUT_W'(r_slot);
        end else if (r_state == ST_EVAL) begin
            r_res_ok     <= rg_hit;
            r_res_handle <= (r_is_get && rg_hit) ? hs_rdata : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PUSH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUSH) && out_free) begin
            r_out_ok     <= r_res_ok;
            r_out_slot   <= r_res_slot;
            r_out_handle <= r_res_handle;
            r_out_low    <= r_low_cnt;
            r_out_high   <= r_high_cnt;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.slot_out   = r_out_slot;
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.low_count  = r_out_low;
    assign o_rsp.high_count = r_out_high;

endmodule

/* tb/sv/tb_two_region_slot_id_allocator.sv */
`timescale 1ns / 100ps

module tb_two_region_slot_id_allocator;
    import trsa_pkg::*;

    // Table geometry as the DUT is built (package defaults).
    localparam int TOTAL    = TOTAL_SLOTS_DEF;
    localparam int LOW_END  = (HIGH_START_DEF < TOTAL_SLOTS_DEF) ? HIGH_START_DEF
                                                                 : TOTAL_SLOTS_DEF;
    localparam int HIGH_LEN = TOTAL - LOW_END;

    // Op code the block does not define; must answer not-ok with zero slot and handle, and change nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int  HOLD_CYCLES   = 300;   // long receiver hold-off for the stall test
    localparam int  RANDOM_ITEMS  = 180;
    localparam int  DRAIN_CYCLES  = 60;    // longer than the worst add
    localparam int  REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 kind;
        logic [HANDLE_W-1:0]  handle;
        logic [SLOT_ID_W-1:0] slot_id;
    } slot_req_t;

    typedef struct packed {
        logic                  ok;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic [HANDLE_W-1:0]   handle_out;
        logic [COUNT_W-1:0]    low_count;
        logic [COUNT_W-1:0]    high_count;
    } slot_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trsa_req_if req_if ();
    trsa_rsp_if rsp_if ();

    two_region_slot_id_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow copy of the slot table
    // ------------------------------------------------------------------
    logic [HANDLE_W-1:0] shadow_handles [TOTAL];
    bit                  shadow_used    [TOTAL];
    int                  shadow_low_cur;
    int                  shadow_high_cur;
    int                  shadow_low_cnt;
    int                  shadow_high_cnt;
    int                  live_slots [$];     // occupied slots, for well-formed removes/gets

    slot_rsp_t pending_results [$];

    // Run statistics
    int n_sent, n_add_ok, n_add_fail, n_remove_ok, n_get_hit, n_miss;
    int n_checked, mismatch_count, peak_high;

    // Knobs shared by the test tasks, the request task and the response process
    bit no_idle;     // suppress random gaps on both sides
    bit hold_rsp;    // ask the receiver process for a long hold-off

    // First free slot in [base, base+len) starting at start, wrapping in the region.
    function automatic int first_free_slot(int start, int base, int len);
        int p;
        for (int i = 0; i < len; i++) begin
            p = start + i;
            if (p >= base + len)
                p -= len;
            if (p < TOTAL && !shadow_used[p])
                return p;
        end
        return -1;
    endfunction

    function automatic void drop_live(int sid);
        for (int i = 0; i < live_slots.size(); i++) begin
            if (live_slots[i] == sid) begin
                live_slots.delete(i);
                return;
            end
        end
    endfunction

    // Apply one accepted request to the shadow table and return the answer due.
    function automatic slot_rsp_t predict_slot_result(slot_req_t r);
        slot_rsp_t res;
        int base, len, cur, s, after, nxt, sid;
        res = '0;
        sid = int'(r.slot_id);
        case (r.op)
            OP_ADD: begin
                base = r.kind ? LOW_END : 0;
                len  = r.kind ? HIGH_LEN : LOW_END;
                cur  = r.kind ? shadow_high_cur : shadow_low_cur;
                s    = -1;
                if (r.handle != '0 && len != 0) begin
                    if (cur < base || cur >= base + len)
                        cur = base;
                    s = first_free_slot(cur, base, len);
                end
                if (s >= 0) begin
                    shadow_handles[s] = r.handle;
                    shadow_used[s]    = 1'b1;
                    if (r.kind)
                        shadow_high_cnt++;
                    else
                        shadow_low_cnt++;
                    // cursor parks on the slot just taken when the region is full
                    after = s + 1;
                    if (after >= base + len)
                        after = base;
                    nxt = first_free_slot(after, base, len);
                    cur = (nxt < 0) ? s : nxt;
                    live_slots.push_back(s);
                    res.ok       = 1'b1;
                    res.slot_out = SLOT_OUT_W'(s);
                    n_add_ok++;
                end else begin
                    n_add_fail++;
                end
                if (r.kind)
                    shadow_high_cur = cur;
                else
                    shadow_low_cur = cur;
            end
            OP_REMOVE: begin
                if (sid < TOTAL && shadow_used[sid]) begin
                    shadow_used[sid] = 1'b0;
                    if (sid >= LOW_END)
                        shadow_high_cnt--;
                    else
                        shadow_low_cnt--;
                    drop_live(sid);
                    res.ok = 1'b1;
                    n_remove_ok++;
                end else begin
                    n_miss++;
                end
            end
            OP_GET: begin
                if (sid < TOTAL && shadow_used[sid]) begin
                    res.ok         = 1'b1;
                    res.handle_out = shadow_handles[sid];
                    n_get_hit++;
                end else begin
                    n_miss++;
                end
            end
            default: n_miss++;
        endcase
        res.low_count  = COUNT_W'(shadow_low_cnt);
        res.high_count = COUNT_W'(shadow_high_cnt);
        if (shadow_high_cnt > peak_high)
            peak_high = shadow_high_cnt;
        return res;
    endfunction

    function automatic slot_req_t make_req(logic [OP_W-1:0] op, logic kind,
                                           logic [HANDLE_W-1:0] handle,
                                           logic [SLOT_ID_W-1:0] sid);
        slot_req_t r;
        r.op      = op;
        r.kind    = kind;
        r.handle  = handle;
        r.slot_id = sid;
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Valid stays high after an accepted beat; the next call
    // either replaces the payload in the same step or drops valid for a gap,
    // so valid gets exactly one assignment per step.
    // ------------------------------------------------------------------
    task automatic send_req(slot_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.op      <= r.op;
        req_if.kind    <= r.kind;
        req_if.handle  <= r.handle;
        req_if.slot_id <= r.slot_id;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(predict_slot_result(r));
        n_sent++;
    endtask

    // Drop valid and wait until every outstanding answer has come back.
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int r;
        stall_left   = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rsp = 1'b0;
            end else if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else if (r < 15) begin
                    rsp_if.ready <= 1'b0;
                    stall_left = $urandom_range(15, 50);
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every response beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        slot_rsp_t got;
        slot_rsp_t exp_rsp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.ok         = rsp_if.ok;
            got.slot_out   = rsp_if.slot_out;
            got.handle_out = rsp_if.handle_out;
            got.low_count  = rsp_if.low_count;
            got.high_count = rsp_if.high_count;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing pending:", $realtime,
                             " ok=%0b slot=%0d h=%h lo=%0d hi=%0d",
                             got.ok, got.slot_out, got.handle_out,
                             got.low_count, got.high_count);
            end else begin
                exp_rsp = pending_results.pop_front();
                n_checked++;
                if (got.ok !== exp_rsp.ok || got.slot_out !== exp_rsp.slot_out ||
                    got.handle_out !== exp_rsp.handle_out ||
                    got.low_count !== exp_rsp.low_count ||
                    got.high_count !== exp_rsp.high_count) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: beat %0d exp ok=%0b slot=%0d h=%h lo=%0d hi=%0d",
                                 $realtime, n_checked,
                                 exp_rsp.ok, exp_rsp.slot_out, exp_rsp.handle_out,
                                 exp_rsp.low_count, exp_rsp.high_count);
                        $display("%0t: beat %0d got ok=%0b slot=%0d h=%h lo=%0d hi=%0d",
                                 $realtime, n_checked,
                                 got.ok, got.slot_out, got.handle_out,
                                 got.low_count, got.high_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every op, null handle, range limits, empty slots.
    task automatic test_directed_ops();
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'h0000));  // empty slot
        send_req(make_req(OP_REMOVE, 1'b0, 16'h0000, 16'h0000));  // remove of empty
        send_req(make_req(OP_GET,    1'b1, 16'hFFFF, 16'hFFFF));  // far out of range
        send_req(make_req(OP_REMOVE, 1'b0, 16'h0000, 16'h0400));  // first id past the table
        send_req(make_req(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF));
        send_req(make_req(OP_ADD,    1'b0, 16'h0000, 16'h0000));  // null handle, low
        send_req(make_req(OP_ADD,    1'b1, 16'h0000, 16'hFFFF));  // null handle, high
        send_req(make_req(OP_ADD,    1'b0, 16'hFFFF, 16'hFFFF));  // -> slot 0
        send_req(make_req(OP_ADD,    1'b0, 16'h0001, 16'h0000));  // -> slot 1
        send_req(make_req(OP_ADD,    1'b1, 16'hA5A5, 16'h0000));  // -> high region start
        send_req(make_req(OP_ADD,    1'b1, 16'h5A5A, 16'h0000));
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'h0000));
        send_req(make_req(OP_GET,    1'b1, 16'h0000, 16'h0001));  // kind is don't-care
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'(LOW_END)));
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'(LOW_END + 1)));
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'(LOW_END - 1)));  // empty, low edge
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'(TOTAL - 1)));    // empty, last slot
        send_req(make_req(OP_REMOVE, 1'b1, 16'hFFFF, 16'h0000));
        send_req(make_req(OP_REMOVE, 1'b0, 16'h0000, 16'h0000));  // already freed
        send_req(make_req(OP_GET,    1'b0, 16'h0000, 16'h0000));
        send_req(make_req(OP_ADD,    1'b0, 16'h8000, 16'h0000));  // cursor already past slot 0
        send_req(make_req(OP_REMOVE, 1'b1, 16'h0000, 16'(LOW_END + 1)));
        send_req(make_req(OP_ADD,    1'b1, 16'h7FFF, 16'h0000));
        drain_results();
    endtask

    // Receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the request side must stall.
    task automatic test_output_backpressure();
        no_idle  = 1'b1;
        hold_rsp = 1'b1;
        for (int i = 0; i < 16; i++)
            send_req(make_req(i[0] ? OP_GET : OP_ADD, i[1], 16'($urandom_range(1, 65535)),
                              16'($urandom_range(0, TOTAL - 1))));
        no_idle = 1'b0;
        drain_results();
    endtask

    // Fill the high region to the brim, bounce adds off it, then free a few
    // slots and refill them through the wrapped cursor.
    task automatic test_high_region_full();
        int sid;
        no_idle = 1'b1;          // first part back-to-back on both sides
        while (shadow_high_cnt < HIGH_LEN) begin
            if (shadow_high_cnt == HIGH_LEN / 2)
                no_idle = 1'b0;
            send_req(make_req(OP_ADD, 1'b1, 16'($urandom_range(1, 65535)), 16'($urandom)));
        end
        repeat (4)
            send_req(make_req(OP_ADD, 1'b1, 16'($urandom_range(1, 65535)), 16'($urandom)));
        repeat (6)
            send_req(make_req(OP_GET, 1'($urandom), 16'($urandom),
                              16'($urandom_range(LOW_END, TOTAL - 1))));
        repeat (6) begin
            sid = $urandom_range(LOW_END, TOTAL - 1);
            send_req(make_req(OP_REMOVE, 1'($urandom), 16'($urandom), 16'(sid)));
        end
        repeat (8)
            send_req(make_req(OP_ADD, 1'b1, 16'($urandom_range(1, 65535)), 16'($urandom)));
        drain_results();
    endtask

    // Mostly well-formed traffic on live slots, with noise mixed in.
    task automatic test_random_traffic();
        slot_req_t r;
        int        pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle   = (n % 150) >= 125;   // periodic stretch with no idling
            r.op      = OP_UNUSED;
            r.kind    = 1'($urandom);
            r.handle  = 16'($urandom);
            r.slot_id = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.op = OP_ADD;
                if ($urandom_range(0, 99) >= 3 && r.handle == '0)
                    r.handle = 16'($urandom_range(1, 65535));
                else if ($urandom_range(0, 99) < 3)
                    r.handle = '0;
            end else if (pick < 85 && live_slots.size() != 0) begin
                r.op      = (pick < 65) ? OP_REMOVE : OP_GET;
                r.slot_id = 16'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
            end else if (pick < 93) begin
                r.op      = pick[0] ? OP_REMOVE : OP_GET;
                r.slot_id = 16'($urandom_range(0, TOTAL - 1));
            end else if (pick < 97) begin
                r.op = pick[0] ? OP_REMOVE : OP_GET;    // raw 16-bit id, mostly out of range
            end
            send_req(r);
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.op      <= OP_ADD;
        req_if.kind    <= 1'b0;
        req_if.handle  <= '0;
        req_if.slot_id <= '0;
        no_idle         = 1'b0;
        hold_rsp        = 1'b0;
        shadow_low_cur  = 0;
        shadow_high_cur = LOW_END;
        shadow_low_cnt  = 0;
        shadow_high_cnt = 0;
        foreach (shadow_used[i]) begin
            shadow_used[i]    = 1'b0;
            shadow_handles[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // request side waits on ready, so the valid-map clear pass is absorbed
        test_directed_ops();
        test_output_backpressure();
        test_high_region_full();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d adds placed, %0d adds refused,",
                 n_sent, n_add_ok, n_add_fail,
                 " %0d removes, %0d get hits, %0d misses",
                 n_remove_ok, n_get_hit, n_miss);
        $display("high region filled to %0d of %0d, one %0d-cycle receiver hold-off,",
                 peak_high, HIGH_LEN, HOLD_CYCLES,
                 " %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("tb_two_region_slot_id_allocator: PASS");
        else
            $display("tb_two_region_slot_id_allocator: FAIL");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #10_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("tb_two_region_slot_id_allocator: FAIL");
        $finish;
    end

endmodule
